/* hdl/i2cmw_pkg.sv */
// shared types and constants of the i2c master write engine
`timescale 1ns / 1ps

package i2cmw_pkg;

  localparam int ERROR_COUNT_WIDTH_DEF = 32;
  localparam int ERR_OUT_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // bit index value of the ack clock
  localparam logic [3:0] ACK_BIT = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS = 2'd2;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // reset values of the configuration registers
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd60;
  localparam logic [7:0] SETUP_TICKS_RST = 8'd1;
  localparam logic [7:0] HIGH_TICKS_RST = 8'd2;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_HOLD       = 4'd1,
    PH_START_A    = 4'd2,
    PH_START_B    = 4'd3,
    PH_ADDR_SETUP = 4'd4,
    PH_ADDR_HIGH  = 4'd5,
    PH_DATA_SETUP = 4'd6,
    PH_DATA_HIGH  = 4'd7,
    PH_STOP_A     = 4'd8,
    PH_STOP_B     = 4'd9,
    PH_STOP_C     = 4'd10
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
    logic       starts_transfer;
    logic       ends_transfer;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] setup_ticks;
    logic [7:0] high_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 scl_release;
    logic                 sda_release;
    logic                 byte_accepted;
    logic                 ready_for_byte;
    logic                 transfer_done;
    logic                 transfer_ok;
    logic [ERR_OUT_W-1:0] error_total;
  } result_t;

endpackage

/* hdl/i2cmw_engine.sv */
// bus phase state machine and shift datapath, one word per step
`timescale 1ns / 1ps

module i2cmw_engine
  import i2cmw_pkg::*;
#(
  parameter int ERROR_COUNT_WIDTH = ERROR_COUNT_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t                       phase_r, phase_nxt;
  logic [7:0]                   shift_r, shift_nxt;
  logic [7:0]                   pend_r, pend_nxt;
  logic [3:0]                   bit_r, bit_nxt;
  logic [7:0]                   wait_r, wait_nxt;
  logic                         acked_r, acked_nxt;
  logic                         stop_r, stop_nxt;
  logic [ERROR_COUNT_WIDTH-1:0] fail_r, fail_nxt;
  logic                         scl_r, scl_nxt;
  logic                         sda_r, sda_nxt;

  logic is_tick;
  logic can_take;
  logic expire;

  assign is_tick  = (item.op == OP_TICK);
  assign can_take = (phase_r == PH_IDLE) || (phase_r == PH_HOLD);
  assign expire   = (wait_r <= 8'd1);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    pend_nxt  = pend_r;
    bit_nxt   = bit_r;
    wait_nxt  = wait_r;
    acked_nxt = acked_r;
    stop_nxt  = stop_r;
    fail_nxt  = fail_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    if (!is_tick) begin
      if (can_take) begin
        stop_nxt = item.ends_transfer;
        if (item.starts_transfer || phase_r == PH_IDLE) begin
          pend_nxt  = item.byte_value;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_START_A;
          wait_nxt  = cfg.high_ticks;
        end else begin
          shift_nxt = item.byte_value;
          bit_nxt   = 4'd0;
          scl_nxt   = 1'b0;
          sda_nxt   = item.byte_value[7];
          phase_nxt = PH_DATA_SETUP;
          wait_nxt  = cfg.setup_ticks;
        end
      end
    end else if (!can_take) begin
      if (!expire) begin
        wait_nxt = wait_r - 8'd1;
      end else begin
        unique case (phase_r)
          PH_START_A: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_START_B;
            wait_nxt  = cfg.high_ticks;
          end
          PH_START_B: begin
            shift_nxt = {cfg.device_address, 1'b0};
            bit_nxt   = 4'd0;
            scl_nxt   = 1'b0;
            sda_nxt   = cfg.device_address[6];
            phase_nxt = PH_ADDR_SETUP;
            wait_nxt  = cfg.setup_ticks;
          end
          PH_ADDR_SETUP: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_ADDR_HIGH;
            wait_nxt  = cfg.high_ticks;
          end
          PH_DATA_SETUP: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_DATA_HIGH;
            wait_nxt  = cfg.high_ticks;
          end
          PH_ADDR_HIGH, PH_DATA_HIGH: begin
            if (bit_r < ACK_BIT) begin
              // next bit, or release sda for the ack clock
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = 4'(bit_r + 4'd1);
              scl_nxt   = 1'b0;
              sda_nxt   = (4'(bit_r + 4'd1) < ACK_BIT) ? shift_r[6] : 1'b1;
              phase_nxt = (phase_r == PH_ADDR_HIGH) ? PH_ADDR_SETUP : PH_DATA_SETUP;
              wait_nxt  = cfg.setup_ticks;
            end else begin
              if (item.sda_in) begin
                acked_nxt = 1'b0;
              end
              scl_nxt = 1'b0;
              if (phase_r == PH_ADDR_HIGH) begin
                shift_nxt = pend_r;
                bit_nxt   = 4'd0;
                sda_nxt   = pend_r[7];
                phase_nxt = PH_DATA_SETUP;
                wait_nxt  = cfg.setup_ticks;
              end else if (stop_r) begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_STOP_A;
                wait_nxt  = cfg.high_ticks;
              end else begin
                phase_nxt = PH_HOLD;
                wait_nxt  = 8'd0;
              end
            end
          end
          PH_STOP_A: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_STOP_B;
            wait_nxt  = cfg.high_ticks;
          end
          PH_STOP_B: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_STOP_C;
            wait_nxt  = cfg.high_ticks;
          end
          PH_STOP_C: begin
            if (!acked_r) begin
              fail_nxt = fail_r + 1'b1;
            end
            acked_nxt = 1'b1;
            stop_nxt  = 1'b0;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
            wait_nxt  = 8'd0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            wait_nxt  = 8'd0;
          end
        endcase
      end
    end
  end

  // result word
  always_comb begin
    res.scl_release    = scl_nxt;
    res.sda_release    = sda_nxt;
    res.byte_accepted  = !is_tick && can_take;
    res.ready_for_byte = (phase_nxt == PH_IDLE) || (phase_nxt == PH_HOLD);
    res.transfer_done  = is_tick && (phase_r == PH_STOP_C) && expire;
    res.transfer_ok    = is_tick && (phase_r == PH_STOP_C) && expire && acked_r;
    res.error_total    = ERR_OUT_W'(fail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= 8'd0;
      pend_r  <= 8'd0;
      bit_r   <= 4'd0;
      wait_r  <= 8'd0;
      acked_r <= 1'b1;
      stop_r  <= 1'b0;
      fail_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      pend_r  <= pend_nxt;
      bit_r   <= bit_nxt;
      wait_r  <= wait_nxt;
      acked_r <= acked_nxt;
      stop_r  <= stop_nxt;
      fail_r  <= fail_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fail_steps: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && fail_r != $past(fail_r) |->
      fail_r == ERROR_COUNT_WIDTH'($past(fail_r) + 1'b1))
    else $error("error counter moved by more than one");
  a_idle_acked: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> acked_r && !stop_r)
    else $error("ack record not cleared in idle");
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= ACK_BIT)
    else $error("bit index past ack clock");
`endif

endmodule

/* hdl/i2c_master_write_engine_core.sv */
// top level: config registers, input register, engine and output register
`timescale 1ns / 1ps

// channel  | direction | handshake              | word
// in_      | input     | in_valid / in_stall    | op, byte, start/end flags, sda level
// out_     | output    | out_valid / out_stall  | line levels, status, error count
// cfg_     | input     | cfg_valid / cfg_ready  | register index, write data
//
// each word is registered on entry in the input register and its result is registered in the output register,
// so one word per clock is sustained while the output is not stalled
// the engine state advances only when the input register hands a word on to
// the output register, a stalled output holds both stages
// reset is synchronous, active low: bus idle, both lines released, error count zero
// cfg_ready is always high, writes to an index past the list are dropped

module i2c_master_write_engine_core
  import i2cmw_pkg::*;
#(
  parameter int ERROR_COUNT_WIDTH = ERROR_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_starts_transfer,
  input  logic                  in_ends_transfer,
  input  logic                  in_sda_in,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl_release,
  output logic                  out_sda_release,
  output logic                  out_byte_accepted,
  output logic                  out_ready_for_byte,
  output logic                  out_transfer_done,
  output logic                  out_transfer_ok,
  output logic [ERR_OUT_W-1:0]  out_error_total,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  item_t   in_item_r;
  logic    in_valid_r;
  result_t out_res_r;
  result_t res;
  logic    out_valid_r;

  logic out_free;
  logic step;
  logic in_take;

  // handshake glue
  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEVICE_ADDRESS_RST;
      cfg_r.setup_ticks    <= SETUP_TICKS_RST;
      cfg_r.high_ticks     <= HIGH_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_data[6:0];
        REG_SETUP_TICKS:    cfg_r.setup_ticks    <= cfg_data;
        REG_HIGH_TICKS:     cfg_r.high_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.op              <= in_op;
      in_item_r.byte_value      <= in_byte_value;
      in_item_r.starts_transfer <= in_starts_transfer;
      in_item_r.ends_transfer   <= in_ends_transfer;
      in_item_r.sda_in          <= in_sda_in;
    end
  end

  i2cmw_engine #(
    .ERROR_COUNT_WIDTH(ERROR_COUNT_WIDTH)
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (in_item_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_scl_release    = out_res_r.scl_release;
  assign out_sda_release    = out_res_r.sda_release;
  assign out_byte_accepted  = out_res_r.byte_accepted;
  assign out_ready_for_byte = out_res_r.ready_for_byte;
  assign out_transfer_done  = out_res_r.transfer_done;
  assign out_transfer_ok    = out_res_r.transfer_ok;
  assign out_error_total    = out_res_r.error_total;

`ifndef SYNTHESIS
  a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.transfer_done |-> out_res_r.ready_for_byte)
    else $error("stop completed but engine not ready");
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.transfer_ok |-> out_res_r.transfer_done)
    else $error("transfer ok without done");
  a_accept_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.byte_accepted |-> !out_res_r.transfer_done)
    else $error("byte taken on a stop tick");
  a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with empty register");
`endif

endmodule
